[src/sedd_pkg.sv]
`timescale 1ns / 1ps

package sedd_pkg;

    localparam int PIX_W            = 8;
    localparam int IDX_W            = 3;
    localparam int CFG_W            = 11;
    localparam int LINE_WIDTH_RESET = 1024;

    // result buffer
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam logic [IDX_W-1:0] IDX_WHITE   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_RED     = 3'd1;
    localparam logic [IDX_W-1:0] IDX_GREEN   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_BLUE    = 3'd3;
    localparam logic [IDX_W-1:0] IDX_CYAN    = 3'd4;
    localparam logic [IDX_W-1:0] IDX_MAGENTA = 3'd5;
    localparam logic [IDX_W-1:0] IDX_YELLOW  = 3'd6;
    localparam logic [IDX_W-1:0] IDX_BLACK   = 3'd7;

    // {red, green, blue} per palette index
    localparam logic [3*PIX_W-1:0] PALETTE [8] = '{
        24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h000000
    };

    typedef struct packed {
        logic [IDX_W-1:0] palette_index;
        logic             row_end;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_even;
        logic wr_odd;
    } lb_ctrl_t;

    // Nearest entry from the per-channel upper-half decisions {r, g, b}.
    function automatic logic [IDX_W-1:0] pal_index(input logic [2:0] hi);
        logic [IDX_W-1:0] idx;
        unique case (hi)
            3'b111: idx = IDX_WHITE;
            3'b100: idx = IDX_RED;
            3'b010: idx = IDX_GREEN;
            3'b001: idx = IDX_BLUE;
            3'b011: idx = IDX_CYAN;
            3'b101: idx = IDX_MAGENTA;
            3'b110: idx = IDX_YELLOW;
            3'b000: idx = IDX_BLACK;
        endcase
        return idx;
    endfunction

endpackage

[src/sedd_if.sv]
`timescale 1ns / 1ps

interface sedd_pix_if;
    logic                       valid;
    logic                       ready;
    logic [sedd_pkg::PIX_W-1:0] red_in;
    logic [sedd_pkg::PIX_W-1:0] green_in;
    logic [sedd_pkg::PIX_W-1:0] blue_in;
    logic                       frame_start;

    modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface sedd_res_if;
    logic                       valid;
    logic                       ready;
    logic [sedd_pkg::IDX_W-1:0] palette_index;
    logic [sedd_pkg::PIX_W-1:0] red_out;
    logic [sedd_pkg::PIX_W-1:0] green_out;
    logic [sedd_pkg::PIX_W-1:0] blue_out;
    logic                       row_end;

    modport source (output valid, palette_index, red_out, green_out, blue_out, row_end,
                    input ready);
    modport sink   (input valid, palette_index, red_out, green_out, blue_out, row_end,
                    output ready);
endinterface

[src/sedd_line_buf.sv]
`timescale 1ns / 1ps

// Error line buffer split into even and odd column banks, one read and one
// write per bank per cycle. Read data is registered and is forwarded from
// the write made on the same edge as the read.
module sedd_line_buf #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 36
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sedd_pkg::lb_ctrl_t ctrl,
    input  logic [AW-1:0]      rd_addr_even,
    input  logic [AW-1:0]      rd_addr_odd,
    input  logic [AW-1:0]      wr_addr_even,
    input  logic [DW-1:0]      wr_data_even,
    input  logic [AW-1:0]      wr_addr_odd,
    input  logic [DW-1:0]      wr_data_odd,
    output logic [DW-1:0]      rd_data_even,
    output logic [DW-1:0]      rd_data_odd,
    output logic               busy
);

    logic [DW-1:0] mem_even [DEPTH];
    logic [DW-1:0] mem_odd  [DEPTH];

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [DW-1:0] rdq_even_reg, rdq_odd_reg;
    logic [AW-1:0] rda_even_reg, rda_odd_reg;
    logic          fw_even_valid_reg, fw_odd_valid_reg;
    logic [AW-1:0] fw_even_addr_reg, fw_odd_addr_reg;
    logic [DW-1:0] fw_even_data_reg, fw_odd_data_reg;

    assign busy = clr_busy_reg;

    // zeroing sweep after reset, one row of both banks per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem_even[clr_addr_reg] <= '0;
            mem_odd[clr_addr_reg]  <= '0;
        end
        else
        begin
            if (ctrl.wr_even)
            begin
                mem_even[wr_addr_even] <= wr_data_even;
            end
            if (ctrl.wr_odd)
            begin
                mem_odd[wr_addr_odd] <= wr_data_odd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdq_even_reg <= mem_even[rd_addr_even];
            rdq_odd_reg  <= mem_odd[rd_addr_odd];
            rda_even_reg <= rd_addr_even;
            rda_odd_reg  <= rd_addr_odd;
        end
        if (ctrl.wr_even)
        begin
            fw_even_addr_reg <= wr_addr_even;
            fw_even_data_reg <= wr_data_even;
        end
        if (ctrl.wr_odd)
        begin
            fw_odd_addr_reg <= wr_addr_odd;
            fw_odd_data_reg <= wr_data_odd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_even_valid_reg <= 1'b0;
            fw_odd_valid_reg  <= 1'b0;
        end
        else
        begin
            fw_even_valid_reg <= ctrl.wr_even && !clr_busy_reg;
            fw_odd_valid_reg  <= ctrl.wr_odd && !clr_busy_reg;
        end
    end

    assign rd_data_even = (fw_even_valid_reg && (fw_even_addr_reg == rda_even_reg))
                          ? fw_even_data_reg : rdq_even_reg;
    assign rd_data_odd  = (fw_odd_valid_reg && (fw_odd_addr_reg == rda_odd_reg))
                          ? fw_odd_data_reg : rdq_odd_reg;

endmodule

[src/sedd_out_buf.sv]
`timescale 1ns / 1ps

// Small result queue between the error loop and the output channel.
module sedd_out_buf (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  sedd_pkg::res_t                    push_data,
    input  logic                              pop,
    output sedd_pkg::res_t                    head,
    output logic [sedd_pkg::OUT_CNT_W-1:0]    count
);

    sedd_pkg::res_t                      ent_reg [sedd_pkg::OUT_DEPTH];
    logic [sedd_pkg::OUT_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [sedd_pkg::OUT_CNT_W-1:0]      cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + sedd_pkg::OUT_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - sedd_pkg::OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + sedd_pkg::OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sedd_pkg::OUT_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = ent_reg[rd_ptr_reg];
    assign count = cnt_reg;

endmodule

[src/serpentine_error_diffusion_dither_core.sv]
// channel  dir  handshake            payload
// -------  ---  -------------------  ----------------------------------------------
// pix      in   valid/ready          red_in, green_in, blue_in, frame_start
// res      out  valid/ready          palette_index, red_out, green_out, blue_out,
//                                    row_end
// cfg      in   cfg_we (no ready)    cfg_wdata = line_width
//
// One pixel per clock sustained; res.valid rises once a result has passed the
// p1 register into the result queue. The loop through the ahead error (add,
// clamp, pick, weight) is combinational from the ahead register back to it; the
// line buffer is read on accept and written back in the next cycle. After reset
// the line buffer is zeroed with pix.ready low. Up to four results queue up
// when res stalls; pix.ready drops once that queue plus the item in flight is
// full.
`timescale 1ns / 1ps

module serpentine_error_diffusion_dither_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int ERROR_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sedd_pix_if.sink                      pix,
    sedd_res_if.source                    res,
    input  logic                          cfg_we,
    input  logic [sedd_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int XW         = $clog2(MAX_WIDTH);          // column index
    localparam int WW         = $clog2(MAX_WIDTH + 1);      // width value
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int EB         = ERROR_BITS;
    localparam int EW         = 3 * ERROR_BITS;              // one line entry
    localparam int TW         = ERROR_BITS + 2;              // corrected sum
    localparam logic [WW-1:0] WID_RESET =
        WW'((sedd_pkg::LINE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                      : sedd_pkg::LINE_WIDTH_RESET);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    // divide by 16, truncating toward zero
    function automatic logic signed [7:0] div16(input logic signed [11:0] m);
        logic [11:0] b;
        b = m + (m[11] ? 12'd15 : 12'd0);
        return b[11:4];
    endfunction

    function automatic logic signed [EB-1:0] sext8(input logic signed [7:0] q);
        return {{(EB-8){q[7]}}, q};
    endfunction

    // a + q saturated to the signed error range
    function automatic logic signed [EB-1:0] sat_add(input logic signed [EB-1:0] a,
                                                     input logic signed [7:0]    q);
        logic [EB:0] s;
        s = {a[EB-1], a} + {{(EB-7){q[7]}}, q};
        if (s[EB] != s[EB-1])
        begin
            return s[EB] ? {1'b1, {(EB-1){1'b0}}} : {1'b0, {(EB-1){1'b1}}};
        end
        return s[EB-1:0];
    endfunction

    // ------------------------------------------------------------------
    // line width register, stored already clamped to 1..MAX_WIDTH
    // ------------------------------------------------------------------
    logic [WW-1:0] wid_reg, wid_next;

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            wid_next = WW'(1);
        end
        else if (int'(cfg_wdata) > MAX_WIDTH)
        begin
            wid_next = WW'(MAX_WIDTH);
        end
        else
        begin
            wid_next = WW'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_reg <= WID_RESET;
        end
        else if (cfg_we)
        begin
            wid_reg <= wid_next;
        end
    end

    // ------------------------------------------------------------------
    // accept stage: position in the row, line buffer read addresses
    // ------------------------------------------------------------------
    logic          accept;
    logic          lb_busy;
    logic [sedd_pkg::OUT_CNT_W-1:0] ob_count;

    logic [XW-1:0] cc_reg;
    logic          gl_reg;       // row runs right to left
    logic          fr_reg;       // first row of the frame

    logic [XW-1:0] wm1, cc0, cc1, xa, pxa;
    logic          gl0, fr0, hn_a, hp_a;

    logic          p1_valid_reg;

    assign accept    = pix.valid && pix.ready;
    assign pix.ready = !lb_busy &&
                       ((ob_count + sedd_pkg::OUT_CNT_W'(p1_valid_reg))
                        < sedd_pkg::OUT_CNT_W'(sedd_pkg::OUT_DEPTH));

    assign wm1  = XW'(wid_reg - WW'(1));
    assign cc0  = pix.frame_start ? '0 : cc_reg;
    assign gl0  = pix.frame_start ? 1'b0 : gl_reg;
    assign fr0  = pix.frame_start ? 1'b1 : fr_reg;
    // a width shrunk mid-row makes this the last pixel of the row
    assign cc1  = (cc0 > wm1) ? wm1 : cc0;
    assign hn_a = (cc1 != wm1);
    assign hp_a = (cc1 != '0);
    assign xa   = gl0 ? (wm1 - cc1) : cc1;
    assign pxa  = gl0 ? (xa + XW'(1)) : (xa - XW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= '0;
            gl_reg <= 1'b0;
            fr_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (hn_a)
            begin
                cc_reg <= cc1 + XW'(1);
                gl_reg <= gl0;
                fr_reg <= fr0;
            end
            else
            begin
                cc_reg <= '0;
                gl_reg <= !gl0;
                fr_reg <= 1'b0;
            end
        end
    end

    // pipeline register into the error stage
    logic [sedd_pkg::PIX_W-1:0] p1_pix_reg [3];
    logic                       p1_fs_reg, p1_fr_reg, p1_hn_reg, p1_hp_reg;
    logic [XW-1:0]              p1_x_reg, p1_px_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_pix_reg[0] <= pix.red_in;
            p1_pix_reg[1] <= pix.green_in;
            p1_pix_reg[2] <= pix.blue_in;
            p1_fs_reg     <= pix.frame_start;
            p1_fr_reg     <= fr0;
            p1_hn_reg     <= hn_a;
            p1_hp_reg     <= hp_a;
            p1_x_reg      <= xa;
            p1_px_reg     <= pxa;
        end
    end

    // ------------------------------------------------------------------
    // line buffer: column x lives in bank x[0]; x and its neighbor always
    // fall in opposite banks
    // ------------------------------------------------------------------
    sedd_pkg::lb_ctrl_t lb_ctrl;
    logic [BAW-1:0]     rd_addr_even, rd_addr_odd, wr_addr_even, wr_addr_odd;
    logic [EW-1:0]      wr_data_even, wr_data_odd, rd_data_even, rd_data_odd;
    logic [EW-1:0]      wx_data, wp_data, xdata, pdata;
    logic               x_odd;

    assign rd_addr_even = xa[0] ? BAW'(pxa >> 1) : BAW'(xa >> 1);
    assign rd_addr_odd  = xa[0] ? BAW'(xa >> 1)  : BAW'(pxa >> 1);

    assign x_odd        = p1_x_reg[0];
    assign wr_addr_even = x_odd ? BAW'(p1_px_reg >> 1) : BAW'(p1_x_reg >> 1);
    assign wr_addr_odd  = x_odd ? BAW'(p1_x_reg >> 1)  : BAW'(p1_px_reg >> 1);
    assign wr_data_even = x_odd ? wp_data : wx_data;
    assign wr_data_odd  = x_odd ? wx_data : wp_data;

    assign lb_ctrl.rd_en   = accept;
    assign lb_ctrl.wr_even = p1_valid_reg && (x_odd ? p1_hp_reg : 1'b1);
    assign lb_ctrl.wr_odd  = p1_valid_reg && (x_odd ? 1'b1 : p1_hp_reg);

    assign xdata = x_odd ? rd_data_odd  : rd_data_even;
    assign pdata = x_odd ? rd_data_even : rd_data_odd;

    sedd_line_buf #(
        .DEPTH (BANK_DEPTH),
        .AW    (BAW),
        .DW    (EW)
    ) u_line_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lb_ctrl),
        .rd_addr_even (rd_addr_even),
        .rd_addr_odd  (rd_addr_odd),
        .wr_addr_even (wr_addr_even),
        .wr_data_even (wr_data_even),
        .wr_addr_odd  (wr_addr_odd),
        .wr_data_odd  (wr_data_odd),
        .rd_data_even (rd_data_even),
        .rd_data_odd  (rd_data_odd),
        .busy         (lb_busy)
    );

    // ------------------------------------------------------------------
    // error stage, one lane per channel (0 red, 1 green, 2 blue).
    // Palette corners are all 0/255, so the nearest entry is chosen per
    // channel: upper half (>= 128) goes to 255. No ties are possible.
    // ------------------------------------------------------------------
    logic [2:0] hi_bits;

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic signed [EB-1:0]       ahead_reg, diag_reg;
        logic signed [EB-1:0]       ahead_next, diag_next;
        logic signed [EB-1:0]       ah, dg, bx, bp;
        logic signed [TW-1:0]       t;
        logic [sedd_pkg::PIX_W-1:0] v;
        logic signed [8:0]          e;
        logic signed [11:0]         e12, m7, m5, m3;
        logic signed [7:0]          q7, q5, q3, q1;

        // frame start drops the carried row errors; first row ignores the buffer
        assign ah = p1_fs_reg ? '0 : ahead_reg;
        assign dg = p1_fs_reg ? '0 : diag_reg;
        assign bx = p1_fr_reg ? '0 : xdata[c*EB +: EB];
        assign bp = pdata[c*EB +: EB];

        assign t = $signed({{(TW-8){1'b0}}, p1_pix_reg[c]})
                 + $signed({{2{ah[EB-1]}}, ah})
                 + $signed({{2{bx[EB-1]}}, bx});

        always_comb
        begin
            if (t[TW-1])
            begin
                v = '0;
            end
            else if (t[TW-2:8] != '0)
            begin
                v = sedd_pkg::PIX_MAX;
            end
            else
            begin
                v = t[7:0];
            end
        end

        assign e   = v[7] ? ($signed({1'b0, v}) - 9'sd255) : $signed({1'b0, v});
        assign e12 = {{3{e[8]}}, e};
        assign m7  = (e12 <<< 3) - e12;
        assign m5  = (e12 <<< 2) + e12;
        assign m3  = (e12 <<< 1) + e12;
        assign q7  = div16(m7);
        assign q5  = div16(m5);
        assign q3  = div16(m3);
        assign q1  = div16(e12);

        // error aimed past the row end is dropped
        assign ahead_next = p1_hn_reg ? sext8(q7) : '0;
        assign diag_next  = p1_hn_reg ? sext8(q1) : '0;

        assign wx_data[c*EB +: EB] = sat_add(dg, q5);
        assign wp_data[c*EB +: EB] = sat_add(bp, q3);
        assign hi_bits[2-c]        = v[7];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ahead_reg <= '0;
                diag_reg  <= '0;
            end
            else if (p1_valid_reg)
            begin
                ahead_reg <= ahead_next;
                diag_reg  <= diag_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // result queue and output channel
    // ------------------------------------------------------------------
    sedd_pkg::res_t push_data, head;
    logic           pop;

    assign push_data.palette_index = sedd_pkg::pal_index(hi_bits);
    assign push_data.row_end       = !p1_hn_reg;
    assign pop                     = res.valid && res.ready;

    sedd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p1_valid_reg),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (ob_count)
    );

    assign res.valid         = (ob_count != '0);
    assign res.palette_index = head.palette_index;
    assign res.red_out       = sedd_pkg::PALETTE[head.palette_index][23:16];
    assign res.green_out     = sedd_pkg::PALETTE[head.palette_index][15:8];
    assign res.blue_out      = sedd_pkg::PALETTE[head.palette_index][7:0];
    assign res.row_end       = head.row_end;

endmodule

[src/sedd_chk.sv]
`timescale 1ns / 1ps

module sedd_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [sedd_pkg::IDX_W-1:0] palette_index,
    input logic [sedd_pkg::PIX_W-1:0] red_out,
    input logic [sedd_pkg::PIX_W-1:0] green_out,
    input logic [sedd_pkg::PIX_W-1:0] blue_out,
    input logic                       row_end
);

    // transactions taken in but not yet delivered
    logic [3:0] open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(palette_index) && $stable(row_end))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 4'd0)
        else $error("result without a pending pixel");

    a_palette: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((palette_index == sedd_pkg::IDX_WHITE) ==
             (red_out == 8'hFF && green_out == 8'hFF && blue_out == 8'hFF)) &&
            ((palette_index == sedd_pkg::IDX_BLACK) ==
             (red_out == 8'h00 && green_out == 8'h00 && blue_out == 8'h00)))
        else $error("palette color does not match index");

endmodule

bind serpentine_error_diffusion_dither_core sedd_chk u_sedd_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pix.valid),
    .in_ready      (pix.ready),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .palette_index (res.palette_index),
    .red_out       (res.red_out),
    .green_out     (res.green_out),
    .blue_out      (res.blue_out),
    .row_end       (res.row_end)
);

[verif/tb_serpentine_error_diffusion_dither_core.sv]
`timescale 1ns / 1ps

module tb_serpentine_error_diffusion_dither_core;

    // Block defaults: line buffer depth and error word size.
    localparam int LINE_MAX      = 1024;
    localparam int ERR_BITS      = 12;
    localparam int ERR_HI        = (1 << (ERR_BITS - 1)) - 1;
    localparam int ERR_LO        = -ERR_HI - 1;
    localparam int RANDOM_PIXELS = 1700;

    // Pixel content styles for a burst of random pixels.
    typedef enum int {TONE_ANY, TONE_FLAT, TONE_EXTREME, TONE_MID} tone_e;

    // One dithered output pixel.
    typedef struct {
        logic [sedd_pkg::IDX_W-1:0] index;
        logic [sedd_pkg::PIX_W-1:0] red;
        logic [sedd_pkg::PIX_W-1:0] green;
        logic [sedd_pkg::PIX_W-1:0] blue;
        logic                       row_end;
    } dither_dot_t;

    // Tracks the dither state and the dots still owed by the block.
    class dither_board;
        logic [sedd_pkg::CFG_W-1:0] line_width;
        int               below_err [3][LINE_MAX];
        int               ahead_err [3];
        int               diag_err [3];
        int               column;
        bit               going_left;
        bit               first_row;
        dither_dot_t      owed_dots [$];
        int               errors;

        function new();
            line_width = sedd_pkg::CFG_W'(sedd_pkg::LINE_WIDTH_RESET);
            foreach (below_err[c, i])
                below_err[c][i] = 0;
            clear_row();
            column     = 0;
            going_left = 1'b0;
            first_row  = 1'b1;
            errors     = 0;
        endfunction

        function void clear_row();
            for (int c = 0; c < 3; c++)
            begin
                ahead_err[c] = 0;
                diag_err[c]  = 0;
            end
        endfunction

        function int clip_err(int v);
            if (v < ERR_LO)
                return ERR_LO;
            if (v > ERR_HI)
                return ERR_HI;
            return v;
        endfunction

        // channel 0 red, 1 green, 2 blue
        function int pal_chan(int idx, int c);
            return int'(sedd_pkg::PALETTE[idx][sedd_pkg::PIX_W*(2-c) +: sedd_pkg::PIX_W]);
        endfunction

        // Accepted pixel: advance the diffusion state, queue the owed dot.
        function void note_pixel(logic [sedd_pkg::PIX_W-1:0] r,
                                 logic [sedd_pkg::PIX_W-1:0] g,
                                 logic [sedd_pkg::PIX_W-1:0] b, logic fs);
            int          w;
            int          x;
            int          px;
            bit          has_prev;
            bit          has_next;
            int          src [3];
            int          v [3];
            int          t;
            int          d;
            int          e;
            int          best;
            int          best_idx;
            dither_dot_t dot;

            src[0] = r;
            src[1] = g;
            src[2] = b;
            w = line_width;
            if (w < 1)
                w = 1;
            if (w > LINE_MAX)
                w = LINE_MAX;

            if (fs)
            begin
                column     = 0;
                going_left = 1'b0;
                first_row  = 1'b1;
                clear_row();
            end
            // width shrunk under a row in progress: this pixel closes the row
            if (column >= w)
                column = w - 1;

            x        = going_left ? (w - 1 - column) : column;
            has_prev = column > 0;
            has_next = column < w - 1;
            px       = going_left ? x + 1 : x - 1;

            for (int c = 0; c < 3; c++)
            begin
                t = src[c] + ahead_err[c];
                if (!first_row)
                    t += below_err[c][x];
                if (t < 0)
                    t = 0;
                if (t > 255)
                    t = 255;
                v[c] = t;
            end

            best     = -1;
            best_idx = 0;
            for (int i = 0; i < 8; i++)
            begin
                d = 0;
                for (int c = 0; c < 3; c++)
                begin
                    e = v[c] - pal_chan(i, c);
                    d += e * e;
                end
                if (best < 0 || d < best)
                begin
                    best     = d;
                    best_idx = i;
                end
            end

            // int division truncates toward zero, as the weights require
            for (int c = 0; c < 3; c++)
            begin
                e = v[c] - pal_chan(best_idx, c);
                if (has_prev)
                    below_err[c][px] = clip_err(below_err[c][px] + (e * 3) / 16);
                below_err[c][x] = clip_err(diag_err[c] + (e * 5) / 16);
                if (has_next)
                begin
                    ahead_err[c] = clip_err((e * 7) / 16);
                    diag_err[c]  = clip_err(e / 16);
                end
                else
                begin
                    ahead_err[c] = 0;
                    diag_err[c]  = 0;
                end
            end

            dot.index   = sedd_pkg::IDX_W'(best_idx);
            dot.red     = sedd_pkg::PIX_W'(pal_chan(best_idx, 0));
            dot.green   = sedd_pkg::PIX_W'(pal_chan(best_idx, 1));
            dot.blue    = sedd_pkg::PIX_W'(pal_chan(best_idx, 2));
            dot.row_end = !has_next;
            owed_dots.push_back(dot);

            if (has_next)
                column++;
            else
            begin
                column     = 0;
                going_left = !going_left;
                first_row  = 1'b0;
                clear_row();
            end
        endfunction

        // Compare one result transaction with the oldest owed dot.
        function void check_result(dither_dot_t got);
            dither_dot_t                want;
            logic [sedd_pkg::PIX_W-1:0] want_f [5];
            logic [sedd_pkg::PIX_W-1:0] got_f [5];
            string                      names [5];

            if (owed_dots.size() == 0)
            begin
                $display("%0t: result with nothing owed, palette_index %0d",
                         $time, got.index);
                errors++;
                return;
            end
            want  = owed_dots.pop_front();
            names = '{"palette_index", "red_out", "green_out", "blue_out", "row_end"};
            want_f = '{sedd_pkg::PIX_W'(want.index), want.red, want.green, want.blue,
                       sedd_pkg::PIX_W'(want.row_end)};
            got_f  = '{sedd_pkg::PIX_W'(got.index), got.red, got.green, got.blue,
                       sedd_pkg::PIX_W'(got.row_end)};
            for (int f = 0; f < 5; f++)
            begin
                if (got_f[f] !== want_f[f])
                begin
                    $display("%0t: %s expected %0d actual %0d",
                             $time, names[f], want_f[f], got_f[f]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [sedd_pkg::CFG_W-1:0] cfg_wdata;

    sedd_pix_if pix ();
    sedd_res_if res ();

    dither_board board;
    int          pix_idle_pct = 15;   // sender gap chance, percent per cycle
    int          res_idle_pct = 15;   // receiver stall chance, percent per cycle
    int          pixels_sent;

    always #1 clk = ~clk;

    serpentine_error_diffusion_dither_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Receiver: random stalls, rate set per burst.
    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= res_idle_pct);

    // Result monitor: a transaction completes on valid && ready at the edge.
    always @(posedge clk)
    begin : watch_results
        dither_dot_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got.index   = res.palette_index;
            got.red     = res.red_out;
            got.green   = res.green_out;
            got.blue    = res.blue_out;
            got.row_end = res.row_end;
            board.check_result(got);
        end
    end

    // Offer one pixel, with random gaps first; returns after the transaction.
    task automatic send_pixel(logic [sedd_pkg::PIX_W-1:0] r, logic [sedd_pkg::PIX_W-1:0] g,
                              logic [sedd_pkg::PIX_W-1:0] b, logic fs);
        while ($urandom_range(99) < pix_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.red_in      <= r;
        pix.green_in    <= g;
        pix.blue_in     <= b;
        pix.frame_start <= fs;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        board.note_pixel(r, g, b, fs);
        pixels_sent++;
    endtask

    // Width change only with the block drained; once the last result is out the
    // pipeline is empty, so a short pause after it is plenty.
    task automatic set_width(int unsigned w);
        pix.valid <= 1'b0;
        while (board.owed_dots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sedd_pkg::CFG_W'(w);
        @(posedge clk);
        cfg_we <= 1'b0;
        board.line_width = sedd_pkg::CFG_W'(w);
    endtask

    function automatic logic [sedd_pkg::PIX_W-1:0] pick_level(tone_e tone, int base);
        int n;
        case (tone)
            TONE_FLAT:    n = base + int'($urandom_range(16)) - 8;
            TONE_EXTREME: n = $urandom_range(1) ? 255 : 0;
            TONE_MID:     n = 120 + int'($urandom_range(16));
            default:      n = $urandom_range(255);
        endcase
        if (n < 0)
            n = 0;
        if (n > 255)
            n = 255;
        return sedd_pkg::PIX_W'(n);
    endfunction

    initial
    begin
        int unsigned w;
        int          count;
        tone_e       tone;
        int          base_r;
        int          base_g;
        int          base_b;
        logic        fs;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        pix.valid       <= 1'b0;
        pix.red_in      <= '0;
        pix.green_in    <= '0;
        pix.blue_in     <= '0;
        pix.frame_start <= 1'b0;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset width, black and white, every palette colour,
        // values around mid-scale where the pick flips.
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        for (int i = sedd_pkg::IDX_RED; i <= sedd_pkg::IDX_YELLOW; i++)
            send_pixel(sedd_pkg::PALETTE[i][23:16], sedd_pkg::PALETTE[i][15:8],
                       sedd_pkg::PALETTE[i][7:0], 1'b0);
        send_pixel(8'd127, 8'd127, 8'd127, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);

        // Zero width acts as one, and shrinks the open row: every pixel ends a row.
        set_width(0);
        send_pixel(8'd128, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd200, 8'd60, 8'd100, 1'b0);
        send_pixel(8'd90, 8'd180, 8'd20, 1'b0);

        // Oversized width acts as the line buffer depth.
        set_width(2047);
        send_pixel(8'd200, 8'd30, 8'd90, 1'b1);
        send_pixel(8'd10, 8'd250, 8'd5, 1'b0);

        // Narrow serpentine with a frame restart partway through.
        set_width(3);
        send_pixel(8'd100, 8'd100, 8'd100, 1'b0);
        send_pixel(8'd140, 8'd60, 8'd200, 1'b0);
        send_pixel(8'd30, 8'd220, 8'd128, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd77, 8'd177, 8'd250, 1'b1);
        send_pixel(8'd255, 8'd1, 8'd128, 1'b0);
        send_pixel(8'd64, 8'd192, 8'd32, 1'b0);

        // Random bursts: mostly narrow rows so the serpentine turns often;
        // now and then an extreme width, left open so the next burst shrinks it.
        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(4))
                    0:       w = 2047;
                    1:       w = 1024;
                    2:       w = 1025;
                    3:       w = 0;
                    default: w = $urandom_range(96, 13);
                endcase
            end
            else
                w = $urandom_range(12, 1);
            set_width(w);

            // about one burst in five runs with no gaps or stalls
            pix_idle_pct = ($urandom_range(4) == 0) ? 0 : 15;
            res_idle_pct = pix_idle_pct;

            tone   = tone_e'($urandom_range(3));
            base_r = $urandom_range(255);
            base_g = $urandom_range(255);
            base_b = $urandom_range(255);
            count  = $urandom_range(80, 20);
            for (int n = 0; n < count; n++)
            begin
                // mostly a clean frame from the first pixel, rare restarts inside
                fs = (n == 0 && $urandom_range(9) < 7) || ($urandom_range(49) == 0);
                send_pixel(pick_level(tone, base_r), pick_level(tone, base_g),
                           pick_level(tone, base_b), fs);
            end
        end

        pix.valid <= 1'b0;
        while (board.owed_dots.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("PASS serpentine_error_diffusion_dither_core");
        else
            $display("FAIL serpentine_error_diffusion_dither_core");
        $finish;
    end

    // Watchdog: far beyond a correct run, clearing pass included.
    initial
    begin
        #1_000_000;
        $display("FAIL serpentine_error_diffusion_dither_core");
        $finish;
    end

endmodule
